@@ rtl/frdr_pkg.sv @@
// shared types and constants for the fresnel reflectance pipeline
package frdr_pkg;

  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned DivSteps  = 31;

  localparam logic [16:0] OneQ16 = 17'h1_0000;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic [63:0] HalfLsb = 64'h0000_4000_0000_0000;

  // one beat inside the square root row
  typedef struct packed {
    logic [61:0] rest;
    logic [61:0] root;
    logic [15:0] c;
    logic [15:0] ni;
    logic [31:0] nt2;
    logic        tir;
  } sqrt_t;

  // one beat inside the divider row, two ratios side by side
  typedef struct packed {
    logic [48:0] rem1;
    logic [30:0] quo1;
    logic [48:0] den1;
    logic        one1;
    logic [32:0] rem2;
    logic [30:0] quo2;
    logic [32:0] den2;
    logic        one2;
    logic        tir;
  } div_t;

endpackage

@@ rtl/frdr_if.sv @@
// valid/ready channel interfaces for input and result beats
interface frdr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cos_incident;
  logic [15:0] index_incident;
  logic [15:0] index_transmitted;

  modport source (output valid, output cos_incident, output index_incident,
                  output index_transmitted, input ready);
  modport sink (input valid, input cos_incident, input index_incident,
                input index_transmitted, output ready);
endinterface

interface frdr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] reflectance;
  logic        total_internal;

  modport source (output valid, output reflectance, output total_internal,
                  input ready);
  modport sink (input valid, input reflectance, input total_internal,
                output ready);
endinterface

@@ rtl/fresnel_dielectric_reflectance_core.sv @@
// top level: unpolarized fresnel reflectance pipeline
//   channel  dir  payload
//   in_i     in   cos_incident, index_incident, index_transmitted
//   out_o    out  reflectance, total_internal
// one beat per cycle while out_o takes results; an input beat reaches the result beat
// through four front stages, the 31-cell square root row, two ratio stages,
// the 31-cell divider row and two back stages
// every stage holds its own valid, so bubbles close up and a stalled result
// only blocks the stages behind it once they are all full
// reset clears the valid bits only; there is no clearing pass
module fresnel_dielectric_reflectance_core (
  input  logic clk_i,
  input  logic rst_ni,
  frdr_in_if.sink    in_i,
  frdr_out_if.source out_o
);
  import frdr_pkg::*;

  // stage valids and readies
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q, g_v_q, h_v_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy, h_rdy;

  logic [15:0] a_c_q, a_ni_q, a_nt_q;
  logic [15:0] b_c_q, b_ni_q;
  logic [31:0] b_c2_q, b_ni2_q, b_nt2_q;
  logic [15:0] c_c_q, c_ni_q;
  logic [31:0] c_nt2_q;
  logic [62:0] c_lhs_q;
  logic [61:0] c_rhs_q;
  logic [15:0] d_c_q, d_ni_q;
  logic [31:0] d_nt2_q;
  logic [61:0] d_diff_q;
  logic        d_tir_q;
  logic [47:0] e_pa_q;
  logic [46:0] e_pb_q;
  logic [31:0] e_qa_q;
  logic [30:0] e_qb_q;
  logic        e_tir_q;
  logic [47:0] f_n1_q;
  logic [48:0] f_d1_q;
  logic [31:0] f_n2_q;
  logic [32:0] f_d2_q;
  logic        f_one1_q, f_one2_q, f_tir_q;
  logic [62:0] g_sq1_q, g_sq2_q;
  logic        g_tir_q;
  logic [16:0] h_refl_q;
  logic        h_tir_q;

  logic        sq_v [SqrtSteps+1];
  logic        sq_r [SqrtSteps+1];
  sqrt_t       sq_d [SqrtSteps+1];
  logic        dv_v [DivSteps+1];
  logic        dv_r [DivSteps+1];
  div_t        dv_d [DivSteps+1];

  logic        a_pos;
  logic [30:0] c_s2;
  logic [30:0] e_w;
  logic [31:0] g_r1, g_r2;
  logic [63:0] h_sum, h_rnd;
  logic [16:0] h_q;

  // ready chain, back to front
  assign h_rdy = !h_v_q || out_o.ready;
  assign g_rdy = !g_v_q || h_rdy;
  assign dv_r[DivSteps] = g_rdy;
  assign f_rdy = !f_v_q || dv_r[0];
  assign e_rdy = !e_v_q || f_rdy;
  assign sq_r[SqrtSteps] = e_rdy;
  assign d_rdy = !d_v_q || sq_r[0];
  assign c_rdy = !c_v_q || d_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign in_i.ready = a_rdy;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_i.valid;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
      if (e_rdy) e_v_q <= sq_v[SqrtSteps];
      if (f_rdy) f_v_q <= e_v_q;
      if (g_rdy) g_v_q <= dv_v[DivSteps];
      if (h_rdy) h_v_q <= g_v_q;
    end
  end

  // side selection and cosine magnitude
  assign a_pos = !in_i.cos_incident[15] && (in_i.cos_incident != 16'd0);

  always_ff @(posedge clk_i) begin
    if (in_i.valid && a_rdy) begin
      a_c_q  <= a_pos ? in_i.cos_incident : 16'(~in_i.cos_incident + 16'd1);
      a_ni_q <= a_pos ? in_i.index_incident : in_i.index_transmitted;
      a_nt_q <= a_pos ? in_i.index_transmitted : in_i.index_incident;
    end
  end

  // squares of cosine and indices
  always_ff @(posedge clk_i) begin
    if (a_v_q && b_rdy) begin
      b_c_q   <= a_c_q;
      b_ni_q  <= a_ni_q;
      b_c2_q  <= a_c_q * a_c_q;
      b_ni2_q <= a_ni_q * a_ni_q;
      b_nt2_q <= a_nt_q * a_nt_q;
    end
  end

  // scaled sine squared against transmitted index
  assign c_s2 = OneQ30 - b_c2_q[30:0];

  always_ff @(posedge clk_i) begin
    if (b_v_q && c_rdy) begin
      c_c_q   <= b_c_q;
      c_ni_q  <= b_ni_q;
      c_nt2_q <= b_nt2_q;
      c_lhs_q <= {31'd0, b_ni2_q} * {32'd0, c_s2};
      c_rhs_q <= {b_nt2_q, 30'd0};
    end
  end

  // total internal reflection test and root radicand
  always_ff @(posedge clk_i) begin
    if (c_v_q && d_rdy) begin
      d_c_q    <= c_c_q;
      d_ni_q   <= c_ni_q;
      d_nt2_q  <= c_nt2_q;
      d_tir_q  <= c_lhs_q >= {1'b0, c_rhs_q};
      d_diff_q <= 62'({1'b0, c_rhs_q} - c_lhs_q);
    end
  end

  // square root row
  assign sq_v[0] = d_v_q;
  assign sq_d[0] = '{rest: d_diff_q, root: 62'd0, c: d_c_q, ni: d_ni_q,
                     nt2: d_nt2_q, tir: d_tir_q};

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    frdr_sqrt_cell #(
      .BitPos(60 - 2 * k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_v[k]),
      .ready_o(sq_r[k]),
      .data_i (sq_d[k]),
      .valid_o(sq_v[k+1]),
      .ready_i(sq_r[k+1]),
      .data_o (sq_d[k+1])
    );
  end

  // ratio terms
  assign e_w = sq_d[SqrtSteps].root[30:0];

  always_ff @(posedge clk_i) begin
    if (sq_v[SqrtSteps] && e_rdy) begin
      e_pa_q  <= sq_d[SqrtSteps].nt2 * sq_d[SqrtSteps].c;
      e_pb_q  <= sq_d[SqrtSteps].ni * e_w;
      e_qa_q  <= sq_d[SqrtSteps].ni * sq_d[SqrtSteps].c;
      e_qb_q  <= e_w;
      e_tir_q <= sq_d[SqrtSteps].tir;
    end
  end

  // numerators, denominators and the magnitude-one cases
  always_ff @(posedge clk_i) begin
    if (e_v_q && f_rdy) begin
      f_n1_q   <= (e_pa_q >= {1'b0, e_pb_q}) ? e_pa_q - {1'b0, e_pb_q}
                                             : {1'b0, e_pb_q} - e_pa_q;
      f_d1_q   <= {1'b0, e_pa_q} + {2'b0, e_pb_q};
      f_n2_q   <= (e_qa_q >= {1'b0, e_qb_q}) ? e_qa_q - {1'b0, e_qb_q}
                                             : {1'b0, e_qb_q} - e_qa_q;
      f_d2_q   <= {1'b0, e_qa_q} + {2'b0, e_qb_q};
      f_one1_q <= (e_pa_q == 48'd0 && e_pb_q == 47'd0) || (e_pb_q == 47'd0)
                  || (e_pa_q == 48'd0);
      f_one2_q <= (e_qa_q == 32'd0) || (e_qb_q == 31'd0);
      f_tir_q  <= e_tir_q;
    end
  end

  // divider row
  assign dv_v[0] = f_v_q;
  assign dv_d[0] = '{rem1: {1'b0, f_n1_q}, quo1: 31'd0, den1: f_d1_q, one1: f_one1_q,
                     rem2: {1'b0, f_n2_q}, quo2: 31'd0, den2: f_d2_q, one2: f_one2_q,
                     tir: f_tir_q};

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    frdr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_v[k]),
      .ready_o(dv_r[k]),
      .data_i (dv_d[k]),
      .valid_o(dv_v[k+1]),
      .ready_i(dv_r[k+1]),
      .data_o (dv_d[k+1])
    );
  end

  // squared ratios
  assign g_r1 = dv_d[DivSteps].one1 ? OneQ31 : {1'b0, dv_d[DivSteps].quo1};
  assign g_r2 = dv_d[DivSteps].one2 ? OneQ31 : {1'b0, dv_d[DivSteps].quo2};

  always_ff @(posedge clk_i) begin
    if (dv_v[DivSteps] && g_rdy) begin
      g_sq1_q <= {31'd0, g_r1} * {31'd0, g_r1};
      g_sq2_q <= {31'd0, g_r2} * {31'd0, g_r2};
      g_tir_q <= dv_d[DivSteps].tir;
    end
  end

  // average, round half up and saturate
  assign h_sum = {1'b0, g_sq1_q} + {1'b0, g_sq2_q};
  assign h_rnd = h_sum + HalfLsb;
  assign h_q   = h_rnd[63:47];

  always_ff @(posedge clk_i) begin
    if (g_v_q && h_rdy) begin
      h_refl_q <= (g_tir_q || h_q > OneQ16) ? OneQ16 : h_q;
      h_tir_q  <= g_tir_q;
    end
  end

  assign out_o.valid          = h_v_q;
  assign out_o.reflectance    = h_refl_q;
  assign out_o.total_internal = h_tir_q;

`ifndef ASSERT_OFF
  a_tir_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.total_internal |-> out_o.reflectance == OneQ16)
    else $error("total internal beat without full reflectance");
  a_refl_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.reflectance <= OneQ16)
    else $error("reflectance above one");
  a_diff_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && !d_tir_q |-> d_diff_q != 62'd0)
    else $error("zero radicand without total internal reflection");
  a_num_le : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> ({1'b0, f_n1_q} <= f_d1_q) && ({1'b0, f_n2_q} <= f_d2_q))
    else $error("ratio numerator above denominator");
`endif
endmodule

@@ rtl/frdr_sqrt_cell.sv @@
// one digit step of the integer square root row
module frdr_sqrt_cell #(
  parameter int unsigned BitPos = 60
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  frdr_pkg::sqrt_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output frdr_pkg::sqrt_t data_o
);
  import frdr_pkg::*;

  localparam logic [61:0] Bit = 62'(1) << BitPos;

  logic  valid_q;
  sqrt_t data_q, data_d;
  logic [61:0] trial;

  // try the next root bit against the remainder
  always_comb begin
    data_d = data_i;
    trial  = data_i.root + Bit;
    if (data_i.rest >= trial) begin
      data_d.rest = data_i.rest - trial;
      data_d.root = (data_i.root >> 1) + Bit;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ rtl/frdr_div_cell.sv @@
// one quotient bit for both ratios of the divider row
module frdr_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  frdr_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output frdr_pkg::div_t data_o
);
  import frdr_pkg::*;

  logic        valid_q;
  div_t        data_q, data_d;
  logic [49:0] sh1;
  logic [33:0] sh2;

  // restoring step on each ratio
  always_comb begin
    data_d = data_i;
    sh1    = {data_i.rem1, 1'b0};
    sh2    = {data_i.rem2, 1'b0};
    if (sh1 >= {1'b0, data_i.den1}) begin
      data_d.rem1 = 49'(sh1 - {1'b0, data_i.den1});
      data_d.quo1 = {data_i.quo1[29:0], 1'b1};
    end else begin
      data_d.rem1 = sh1[48:0];
      data_d.quo1 = {data_i.quo1[29:0], 1'b0};
    end
    if (sh2 >= {1'b0, data_i.den2}) begin
      data_d.rem2 = 33'(sh2 - {1'b0, data_i.den2});
      data_d.quo2 = {data_i.quo2[29:0], 1'b1};
    end else begin
      data_d.rem2 = sh2[32:0];
      data_d.quo2 = {data_i.quo2[29:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
